// ----- hw/rtl/ptd_pkg.sv -----
// ptd_pkg: shared types and constants for the periodic task dispatcher
// used by ptd_div, periodic_task_dispatcher_core and ptd_checker
package ptd_pkg;

  localparam int unsigned DIV_W       = 31;   // dividend and quotient width
  localparam int unsigned PER_W       = 10;   // period and divisor width
  localparam int unsigned FREQ_MAX    = 1000; // highest legal rate in hertz
  localparam int unsigned BASE_MS     = 1000; // numerator of the period
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned RECIP3      = 683;  // 2^11 / 3, rounded up
  localparam int unsigned RECIP3_SH   = 11;
  localparam int unsigned MAX_RESULTS = 8;    // dispatches per scan

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_TICK  = 3'd1,
    OP_SCAN  = 3'd2,
    OP_RPT   = 3'd3,
    OP_READ  = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REJECT  = 2'd1,
    ST_DUE     = 2'd2,
    ST_NOTHING = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] frequency_hz;
    logic [15:0] start_delay_ms;
    logic [3:0]  task_id;
    logic [31:0] runtime_us;
  } in_t;

  typedef struct packed {
    logic [31:0] run_count;
    logic [31:0] missed_total;
    logic [31:0] overrun_count;
    logic [31:0] last_runtime_us;
    logic [31:0] max_runtime_us;
  } stats_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  task_id_out;
    logic [30:0] missed_periods;
    logic        enabled;
    logic [31:0] run_count;
    logic [31:0] missed_total;
    logic [31:0] overrun_count;
    logic [31:0] last_runtime_us;
    logic [31:0] max_runtime_us;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0]      deadline;
    logic [PER_W-1:0] period;
  } sched_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [PER_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_DIV,
    S_SC_RD,
    S_SC_CHK,
    S_SC_DIV,
    S_SC_NEXT,
    S_ST_RD,
    S_ST_MUL,
    S_ST_UPD,
    S_EMIT
  } state_e;

endpackage

// ----- hw/rtl/periodic_task_dispatcher_core.sv -----
// periodic_task_dispatcher_core: top level of the periodic task dispatcher
// depends on ptd_pkg and ptd_div
//
// Usage: one input channel (in_valid, in_stall, in_item) carries commands:
// add task, tick, scan, report runtime, read stats, reset stats. One output
// channel (out_valid, out_stall, out_item) returns result beats; the final
// beat of a command has last set. A scan returns one beat per due task,
// at most eight, or a single nothing-due beat.
// One command is in work at a time; in_stall stays high until its last beat
// is loaded into the output register, so the next command is taken while
// that beat still waits.
// Tick and rejected commands go straight to the output beat; report, read and
// reset pass the read, multiply and update states first. Add waits on the
// 31-step divider; a scan waits on the same shared divider per due slot.
// Schedule and statistics live in two one-port memories with a registered
// read; each slot is read, updated and written back before the next.
// Reset clears the tick counter and the task count; memories need no clear.
// A stalled output beat holds its value; work goes on until the next beat must load.
module periodic_task_dispatcher_core
  import ptd_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  localparam int unsigned AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  state_e state, state_next;
  state_e ret;

  logic [31:0]   tick;
  logic [3:0]    tasks_added;
  in_t           item;
  logic [AW-1:0] slot;
  logic [3:0]    n;
  logic          held;
  out_t          res;
  logic [19:0]   thr;

  sched_t dl_mem [NUM_TASKS];
  stats_t st_mem [NUM_TASKS];
  sched_t dl_rd, dl_wdata;
  stats_t st_rd, st_wdata;
  logic   dl_we, st_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        accept, out_load;
  logic        add_ok, tid_ok;
  logic [19:0] f_x3;
  logic [10:0] add_num;
  logic [31:0] late;
  logic        due;
  logic        scan_end;
  logic [31:0] first_dl;

  // build one result beat
  function automatic out_t beat(status_e st, logic [3:0] id, logic [30:0] missed,
                                logic en, stats_t s, logic lst);
    out_t b;
    b.status          = st;
    b.task_id_out     = id;
    b.missed_periods  = missed;
    b.enabled         = en;
    b.run_count       = s.run_count;
    b.missed_total    = s.missed_total;
    b.overrun_count   = s.overrun_count;
    b.last_runtime_us = s.last_runtime_us;
    b.max_runtime_us  = s.max_runtime_us;
    b.last            = lst;
    return b;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  assign add_ok  = (in_item.frequency_hz != 16'd0)
                && (in_item.frequency_hz <= 16'(FREQ_MAX))
                && (tasks_added < 4'(NUM_TASKS));
  assign tid_ok  = in_item.task_id < tasks_added;
  assign f_x3    = in_item.frequency_hz[9:0] * 10'(RECIP3);
  assign add_num = 11'(BASE_MS) + 11'(f_x3 >> RECIP3_SH);

  assign late     = tick - dl_rd.deadline;
  assign due      = !late[31];
  assign scan_end = (n == 4'(MAX_RESULTS))
                 || ((5'(slot) + 5'd1) >= {1'b0, tasks_added});
  assign first_dl = tick + ((item.start_delay_ms == 16'd0)
                 ? 32'(div_rsp.quotient[PER_W-1:0]) : 32'(item.start_delay_ms));

  ptd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // memories with registered read at the current slot
  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[slot] <= dl_wdata;
    if (st_we) st_mem[slot] <= st_wdata;
    dl_rd <= dl_mem[slot];
    st_rd <= st_mem[slot];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (in_item.operation)
            OP_ADD:  state_next = add_ok ? S_ADD_DIV : S_EMIT;
            OP_SCAN: state_next = (tasks_added != 4'd0) ? S_SC_RD : S_EMIT;
            OP_RPT, OP_READ, OP_CLEAR: state_next = tid_ok ? S_ST_RD : S_EMIT;
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_ADD_DIV: if (div_rsp.done) state_next = S_EMIT;
      S_SC_RD:   state_next = S_SC_CHK;
      S_SC_CHK:  state_next = !due ? S_SC_NEXT : (held ? S_EMIT : S_SC_DIV);
      S_SC_DIV:  if (div_rsp.done) state_next = S_SC_NEXT;
      S_SC_NEXT: state_next = scan_end ? S_EMIT : S_SC_RD;
      S_ST_RD:   state_next = S_ST_MUL;
      S_ST_MUL:  state_next = S_ST_UPD;
      S_ST_UPD:  state_next = S_EMIT;
      S_EMIT:    if (out_load) state_next = ret;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory writes and divider requests
  always_comb begin
    dl_we    = 1'b0;
    st_we    = 1'b0;
    dl_wdata = dl_rd;
    st_wdata = st_rd;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(add_num);
    div_req.divisor  = in_item.frequency_hz[PER_W-1:0];
    unique case (state)
      S_IDLE: begin
        div_req.start = accept && (in_item.operation == OP_ADD) && add_ok;
      end
      S_ADD_DIV: begin
        dl_we    = div_rsp.done;
        st_we    = div_rsp.done;
        dl_wdata = '{deadline: first_dl, period: div_rsp.quotient[PER_W-1:0]};
        st_wdata = '0;
      end
      S_SC_CHK: begin
        div_req.start    = due && !held;
        div_req.dividend = late[DIV_W-1:0];
        div_req.divisor  = dl_rd.period;
      end
      S_SC_DIV: begin
        dl_we = div_rsp.done;
        st_we = div_rsp.done;
        dl_wdata.deadline = tick - 32'(div_rsp.remainder) + 32'(dl_rd.period);
        st_wdata.missed_total = st_rd.missed_total + 32'(div_rsp.quotient);
      end
      S_ST_UPD: begin
        if (item.operation == OP_RPT) begin
          st_we = 1'b1;
          st_wdata.run_count       = st_rd.run_count + 32'd1;
          st_wdata.last_runtime_us = item.runtime_us;
          if (item.runtime_us > st_rd.max_runtime_us)
            st_wdata.max_runtime_us = item.runtime_us;
          if (item.runtime_us > 32'(thr))
            st_wdata.overrun_count = st_rd.overrun_count + 32'd1;
        end else if (item.operation == OP_CLEAR) begin
          st_we    = 1'b1;
          st_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= S_IDLE;
      tick        <= '0;
      tasks_added <= '0;
      held        <= 1'b0;
      n           <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_item;
            n    <= '0;
            held <= 1'b0;
            ret  <= S_IDLE;
            priority case (in_item.operation)
              OP_ADD: begin
                slot <= tasks_added[AW-1:0];
                res  <= beat(ST_REJECT, 4'd0, '0, 1'b0, '0, 1'b1);
              end
              OP_TICK: begin
                tick <= tick + 32'd1;
                res  <= beat(ST_DONE, 4'd0, '0, 1'b0, '0, 1'b1);
              end
              OP_SCAN: begin
                slot <= '0;
                res  <= beat(ST_NOTHING, 4'd0, '0, 1'b0, '0, 1'b1);
              end
              OP_RPT, OP_READ, OP_CLEAR: begin
                slot <= in_item.task_id[AW-1:0];
                res  <= beat(ST_REJECT, in_item.task_id, '0, 1'b0, '0, 1'b1);
              end
              default: res <= beat(ST_REJECT, 4'd0, '0, 1'b0, '0, 1'b1);
            endcase
          end
        end
        S_ADD_DIV: begin
          if (div_rsp.done) begin
            tasks_added <= tasks_added + 4'd1;
            res         <= beat(ST_DONE, 4'(slot), '0, 1'b1, '0, 1'b1);
          end
        end
        S_SC_CHK: begin
          if (due && held) begin
            held <= 1'b0;
            ret  <= S_SC_CHK;
          end
        end
        S_SC_DIV: begin
          if (div_rsp.done) begin
            held <= 1'b1;
            n    <= n + 4'd1;
            res  <= beat(ST_DUE, 4'(slot), div_rsp.quotient, 1'b0, '0, 1'b0);
          end
        end
        S_SC_NEXT: begin
          if (scan_end) begin
            ret  <= S_IDLE;
            held <= 1'b0;
            if (held) begin
              res.last <= 1'b1;
            end else begin
              res <= beat(ST_NOTHING, 4'd0, '0, 1'b0, '0, 1'b1);
            end
          end else begin
            slot <= slot + AW'(1);
          end
        end
        S_ST_MUL: thr <= dl_rd.period * 10'(US_PER_MS);
        S_ST_UPD: res <= beat(ST_DONE, res.task_id_out, '0, 1'b1, st_wdata, 1'b1);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) out_item <= res;
  end

endmodule

// ----- hw/rtl/ptd_div.sv -----
// ptd_div: restoring divider, one quotient bit per cycle
// depends on ptd_pkg for the request and response structs
module ptd_div
  import ptd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] quo;
  logic [PER_W-1:0] rem;
  logic [PER_W-1:0] dvs;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [PER_W:0]   part;
  logic             fits;

  // one trial subtraction per cycle
  assign part = {rem, quo[DIV_W-1]};
  assign fits = part >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_W);
        done <= 1'b0;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? PER_W'(part - {1'b0, dvs}) : part[PER_W-1:0];
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

// ----- hw/rtl/ptd_checker.sv -----
// ptd_checker: port-level checks on the periodic task dispatcher
// depends on ptd_pkg; bound to periodic_task_dispatcher_core below
module ptd_checker
  import ptd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_item,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  // a command in work blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // only dispatch beats can be followed by more beats
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_DUE |-> out_item.last)
    else $error("non-dispatch beat without last");

  // dispatch beats carry no enabled flag and a zero run count
  a_due_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_DUE |->
      !out_item.enabled && out_item.run_count == 32'd0)
    else $error("dispatch beat carries statistics");

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (.*);
